[src/ltc_pkg.sv]
// shared types, constants and action/status codes for the lru tile tag cache
// no dependencies; imported by every module of the block
package ltc_pkg;

    // slot store geometry
    localparam int SLOTS    = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CAP_W    = 5;
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int STAMP_W  = 32;

    // stream payload widths
    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 16;
    localparam int M_PAD_W  = M_DATA_W - SLOT_W - CNT_W;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PEEK         = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET          = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUT          = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROP_DOMAIN  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROP_VERSION = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROP_ALL     = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] domain;
        logic [63:0] tile;
        logic [31:0] resolution;
        logic [31:0] version;
    } key_t;

    // one word of the tag memory
    typedef struct packed {
        key_t               key;
        logic [STAMP_W-1:0] last_use;
        logic [STAMP_W-1:0] insert_rank;
    } entry_t;

    // controller to scan unit
    typedef struct packed {
        logic              start;
        logic              beat;
        logic [SLOT_W-1:0] idx;
        logic              entry_valid;
        logic [ACT_W-1:0]  action;
        logic [CAP_W-1:0]  capacity;
    } scan_ctrl_t;

    // scan unit to controller, held until the next start
    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  match_idx;
        logic [STAMP_W-1:0] match_rank;
        logic               free_found;
        logic [SLOT_W-1:0]  free_idx;
        logic               best_any;
        logic [SLOT_W-1:0]  best_idx;
        logic [STAMP_W-1:0] best_use;
        logic [STAMP_W-1:0] best_rank;
    } scan_res_t;

endpackage

[src/ltc_tag_ram.sv]
// simple dual port tag memory: one write and one registered read per cycle
// depends on ltc_pkg for the entry type and depth
module ltc_tag_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ltc_pkg::SLOT_W-1:0] waddr,
    input  ltc_pkg::entry_t           wdata,
    input  logic                      re,
    input  logic [ltc_pkg::SLOT_W-1:0] raddr,
    output ltc_pkg::entry_t           rdata
);
    import ltc_pkg::*;

    entry_t mem [SLOTS];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/ltc_scan.sv]
// scan unit: compares each entry read back from the tag memory with the key
// tracks first match, first free slot and lru candidate; flags drop hits
// depends on ltc_pkg
module ltc_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ltc_pkg::scan_ctrl_t  ctrl,
    input  ltc_pkg::key_t        key,
    input  ltc_pkg::entry_t      rd_entry,
    output ltc_pkg::scan_res_t   res,
    output logic                 drop_hit
);
    import ltc_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      enabled;
    logic      key_eq;
    logic      older;

    // slot lies below the enabled capacity
    assign enabled = ctrl.beat && (CAP_W'(ctrl.idx) < ctrl.capacity);
    assign key_eq  = (rd_entry.key == key);

    // least recently used, oldest insert breaking ties
    assign older = !res_reg.best_any
                || (rd_entry.last_use < res_reg.best_use)
                || ((rd_entry.last_use == res_reg.best_use)
                    && (rd_entry.insert_rank < res_reg.best_rank));

    // drop decision for the entry on the read port, every slot counts
    always_comb begin
        drop_hit = 1'b0;
        if (ctrl.beat && ctrl.entry_valid) begin
            case (ctrl.action)
                ACT_DROP_DOMAIN:  drop_hit = (rd_entry.key.domain == key.domain);
                ACT_DROP_VERSION: drop_hit = (rd_entry.key.version == key.version);
                default:          drop_hit = 1'b0;
            endcase
        end
    end

    // accumulate the lookup results over the scan
    always_comb begin
        res_next = res_reg;
        if (ctrl.start) begin
            res_next.found      = 1'b0;
            res_next.free_found = 1'b0;
            res_next.best_any   = 1'b0;
        end else if (enabled) begin
            if (ctrl.entry_valid && key_eq && !res_reg.found) begin
                res_next.found      = 1'b1;
                res_next.match_idx  = ctrl.idx;
                res_next.match_rank = rd_entry.insert_rank;
            end
            if (!ctrl.entry_valid && !res_reg.free_found) begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = ctrl.idx;
            end
            if (ctrl.entry_valid && older) begin
                res_next.best_any  = 1'b1;
                res_next.best_idx  = ctrl.idx;
                res_next.best_use  = rd_entry.last_use;
                res_next.best_rank = rd_entry.insert_rank;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.found      <= 1'b0;
            res_reg.free_found <= 1'b0;
            res_reg.best_any   <= 1'b0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[src/lru_tile_tag_cache_top.sv]
// lru tile tag cache: peek, get, put and the domain/version drops walk the tag memory,
// one read per slot (SCAN), then DRAIN for the last read data, then the update in
// FINISH; drop-all and unused actions go straight from IDLE to FINISH. FINISH waits
// for a free output register. a new item is taken only in IDLE, after the last result
// is loaded; the single read port of the tag memory walking all slots sets the scan length.
// reset (aresetn low, synchronous) clears valid bits, counters, capacity and the
// output register; the tag memory itself is not cleared and needs no clearing pass.
module lru_tile_tag_cache_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: capacity_in_use
    input  logic                          cfg_we,
    input  logic [ltc_pkg::CAP_W-1:0]     cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // domain_key, tile_key, resolution_key, version_key
    input  logic [ltc_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  logic [ltc_pkg::ACT_W-1:0]     s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot, live_count, zero padding
    output logic [ltc_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [ltc_pkg::STATUS_W-1:0]  m_tuser
);
    import ltc_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t              state_reg,      state_next;
    logic [CAP_W-1:0]    cap_reg,        cap_next;
    logic [ACT_W-1:0]    act_reg,        act_next;
    key_t                key_reg,        key_next;
    logic [SLOT_W-1:0]   addr_reg,       addr_next;
    logic                beat_reg,       beat_next;
    logic [SLOT_W-1:0]   beat_idx_reg,   beat_idx_next;
    logic [SLOTS-1:0]    valid_reg,      valid_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic [STAMP_W-1:0]  use_stamp_reg,  use_stamp_next;
    logic [STAMP_W-1:0]  ins_stamp_reg,  ins_stamp_next;
    logic                m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0] m_status_reg,   m_status_next;
    logic [SLOT_W-1:0]   m_slot_reg,     m_slot_next;
    logic [CNT_W-1:0]    m_count_reg,    m_count_next;

    logic                in_xfer;
    logic                out_free;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    entry_t              ram_rdata;
    scan_ctrl_t          scan_ctrl;
    scan_res_t           scan_res;
    logic                drop_hit;
    key_t                in_key;
    logic                take_free;
    logic                target_any;
    logic [SLOT_W-1:0]   target;
    logic [STAMP_W-1:0]  kept_rank;

    // unpack the input transfer
    assign in_key.domain     = s_tdata[31:0];
    assign in_key.tile       = s_tdata[95:32];
    assign in_key.resolution = s_tdata[127:96];
    assign in_key.version    = s_tdata[159:128];

    assign s_tready  = (state_reg == IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // tag memory read walks the slots during the scan
    assign ram_re = (state_reg == SCAN);

    ltc_tag_ram u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // scan unit sees each entry in the cycle after its read
    assign scan_ctrl.start       = in_xfer;
    assign scan_ctrl.beat        = beat_reg;
    assign scan_ctrl.idx         = beat_idx_reg;
    assign scan_ctrl.entry_valid = valid_reg[beat_idx_reg];
    assign scan_ctrl.action      = act_reg;
    assign scan_ctrl.capacity    = cap_reg;

    ltc_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (scan_ctrl),
        .key      (key_reg),
        .rd_entry (ram_rdata),
        .res      (scan_res),
        .drop_hit (drop_hit)
    );

    // put target: matching entry, else lowest free slot, else lru entry
    assign take_free  = !scan_res.found && scan_res.free_found;
    assign target_any = scan_res.found || scan_res.free_found || scan_res.best_any;
    assign target     = scan_res.found      ? scan_res.match_idx :
                        scan_res.free_found ? scan_res.free_idx  : scan_res.best_idx;
    assign kept_rank  = scan_res.found ? scan_res.match_rank : scan_res.best_rank;

    // sequencer and update of the cache state
    always_comb begin
        state_next     = state_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        beat_next      = 1'b0;
        beat_idx_next  = addr_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        use_stamp_next = use_stamp_reg;
        ins_stamp_next = ins_stamp_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_slot_next    = m_slot_reg;
        m_count_next   = m_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = target;
        ram_wdata.key         = key_reg;
        ram_wdata.last_use    = use_stamp_reg + STAMP_W'(1);
        ram_wdata.insert_rank = kept_rank;

        case (state_reg)
            IDLE: begin
                addr_next = '0;
                if (in_xfer) begin
                    act_next = s_tuser;
                    key_next = in_key;
                    case (s_tuser)
                        ACT_PEEK, ACT_GET, ACT_PUT,
                        ACT_DROP_DOMAIN, ACT_DROP_VERSION: state_next = SCAN;
                        default:                           state_next = FINISH;
                    endcase
                end
            end
            SCAN: begin
                beat_next = 1'b1;
                addr_next = addr_reg + SLOT_W'(1);
                if (addr_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = DRAIN;
                end
            end
            DRAIN: begin
                state_next = FINISH;
            end
            FINISH: begin
                if (out_free) begin
                    state_next    = IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_slot_next   = '0;
                    case (act_reg)
                        ACT_PEEK, ACT_GET: begin
                            if (scan_res.found) begin
                                m_slot_next = scan_res.match_idx;
                                if (act_reg == ACT_GET) begin
                                    ram_we         = 1'b1;
                                    use_stamp_next = use_stamp_reg + STAMP_W'(1);
                                end
                            end else begin
                                m_status_next = ST_MISS;
                            end
                        end
                        ACT_PUT: begin
                            if (target_any) begin
                                ram_we         = 1'b1;
                                use_stamp_next = use_stamp_reg + STAMP_W'(1);
                                m_slot_next    = target;
                                if (take_free) begin
                                    ram_wdata.insert_rank = ins_stamp_reg;
                                    ins_stamp_next        = ins_stamp_reg + STAMP_W'(1);
                                    valid_next[target]    = 1'b1;
                                    count_next            = count_reg + CNT_W'(1);
                                end
                            end else begin
                                m_status_next = ST_FULL;
                            end
                        end
                        ACT_DROP_ALL: begin
                            valid_next = '0;
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                    m_count_next = count_next;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        // drops clear the entry as it goes past
        if (drop_hit) begin
            valid_next[beat_idx_reg] = 1'b0;
            if (count_reg != '0) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            cap_reg       <= '0;
            beat_reg      <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            use_stamp_reg <= '0;
            ins_stamp_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            beat_reg      <= beat_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            use_stamp_reg <= use_stamp_next;
            ins_stamp_reg <= ins_stamp_next;
            m_valid_reg   <= m_valid_next;
        end
        act_reg      <= act_next;
        key_reg      <= key_next;
        addr_reg     <= addr_next;
        beat_idx_reg <= beat_idx_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_count_reg  <= m_count_next;
    end

    // result transfer
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_slot_reg};

    // live count tracks the valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("live count differs from number of valid slots");

    // no write back while a scan read is in flight
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re && !beat_reg)
        else $error("tag memory written during scan");

    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while an item is in progress");

    // status code stays within its defined set
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_MISS || m_tuser == ST_FULL))
        else $error("undefined status code on result");

endmodule
